// File: src/kmat_pkg.sv
// ----------------------------------------------------------------------------
// kmat_pkg
// Shared types and constants of the keyed group-by maximum engine.
// ----------------------------------------------------------------------------
package kmat_pkg;

  // table sizes and key width
  localparam int AGENT_SLOTS  = 256;
  localparam int REGION_SLOTS = 128;
  localparam int KEY_BITS     = 64;

  // fixed field widths
  localparam int IN_KEY_W  = 64;
  localparam int RATE_W    = 11;
  localparam int IDX_W     = 8;
  localparam int STAT_W    = 2;

  // derived widths: both tables share one store, region table sits above agent table
  localparam int TOTAL_SLOTS = AGENT_SLOTS + REGION_SLOTS;
  localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int MAX_SLOTS   = (AGENT_SLOTS > REGION_SLOTS) ? AGENT_SLOTS : REGION_SLOTS;
  localparam int SCAN_W      = $clog2(MAX_SLOTS + 1);
  localparam int A_CNT_W     = $clog2(AGENT_SLOTS + 1);
  localparam int R_CNT_W     = $clog2(REGION_SLOTS + 1);
  localparam int CMP_W       = (SCAN_W > IDX_W) ? SCAN_W : IDX_W;

  // maximum given to a freshly inserted key: -1.0 in tenths
  localparam logic signed [RATE_W-1:0] INIT_MAX = -11'sd10;

  // request types
  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // table select
  localparam logic TAB_AGENT  = 1'b0;
  localparam logic TAB_REGION = 1'b1;

  // update status codes
  typedef enum logic [STAT_W-1:0] {
    ST_MATCH  = 2'd0,
    ST_INSERT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // result of the shared compare unit
  typedef struct packed {
    logic                     key_eq;
    logic                     raise;
    logic signed [RATE_W-1:0] new_max;
  } cmp_res_t;

endpackage

// File: src/kmat_store.sv
// ----------------------------------------------------------------------------
// kmat_store
// Key and maximum store for both tables, one write and one registered read port.
// ----------------------------------------------------------------------------
module kmat_store (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [kmat_pkg::ADDR_W-1:0]            wr_addr,
  input  logic [kmat_pkg::KEY_BITS-1:0]          wr_key,
  input  logic signed [kmat_pkg::RATE_W-1:0]     wr_max,
  input  logic                                   rd_en,
  input  logic [kmat_pkg::ADDR_W-1:0]            rd_addr,
  output logic [kmat_pkg::KEY_BITS-1:0]          rd_key,
  output logic signed [kmat_pkg::RATE_W-1:0]     rd_max
);
  import kmat_pkg::*;

  logic [KEY_BITS-1:0]      key_mem [TOTAL_SLOTS];
  logic signed [RATE_W-1:0] max_mem [TOTAL_SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      max_mem[wr_addr] <= wr_max;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_max <= max_mem[rd_addr];
    end
  end

endmodule

// File: src/kmat_cmp.sv
// ----------------------------------------------------------------------------
// kmat_cmp
// Shared compare unit: key equality and signed maximum of rating and stored max.
// ----------------------------------------------------------------------------
module kmat_cmp (
  input  logic [kmat_pkg::KEY_BITS-1:0]      key_a,
  input  logic [kmat_pkg::KEY_BITS-1:0]      key_b,
  input  logic signed [kmat_pkg::RATE_W-1:0] rating,
  input  logic signed [kmat_pkg::RATE_W-1:0] max_in,
  output kmat_pkg::cmp_res_t                 res
);
  import kmat_pkg::*;

  // key match and strict raise of the maximum
  always_comb begin
    res.key_eq  = (key_a == key_b);
    res.raise   = (rating > max_in);
    res.new_max = res.raise ? rating : max_in;
  end

endmodule

// File: src/keyed_max_aggregation_table.sv
// ----------------------------------------------------------------------------
// keyed_max_aggregation_table
// Group-by maximum engine over an agent table and a region table.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. A record request
//   (in_req_type 0) searches the agent table for in_agent_key, then the
//   region table for in_region_key; an absent key is inserted at the next
//   free slot with a maximum of -1.0, and the stored maximum is raised to
//   in_rating when that is larger. A full table reports full and is left
//   alone. A read request (in_req_type 1) returns one slot of one table.
//   Exactly one result follows each request, shown for one cycle with
//   out_valid high; the receiver cannot stall it.
//   A read issues its slot read when accepted, and S_RESP registers the
//   result. A record searches the agent table, then the region table, in
//   S_SEARCH, plus S_INS when the key is absent or the table full; a match
//   ends that table's search early. The key search reads one stored entry
//   per cycle through the single read port of the shared store and one
//   shared compare unit. busy stays high for the whole request and drops in
//   the cycle the result is shown, so the next request can be taken there.
//   Reset clears both fill counts; store contents are not cleared, slots at
//   or beyond the fill count are never returned as valid entries.
// ----------------------------------------------------------------------------
module keyed_max_aggregation_table (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   in_req_type,
  input  logic [kmat_pkg::IN_KEY_W-1:0]          in_agent_key,
  input  logic [kmat_pkg::IN_KEY_W-1:0]          in_region_key,
  input  logic signed [kmat_pkg::RATE_W-1:0]     in_rating,
  input  logic                                   in_read_table,
  input  logic [kmat_pkg::IDX_W-1:0]             in_read_index,
  output logic                                   out_valid,
  output logic [kmat_pkg::STAT_W-1:0]            out_agent_status,
  output logic [kmat_pkg::STAT_W-1:0]            out_region_status,
  output logic                                   out_entry_valid,
  output logic [kmat_pkg::IN_KEY_W-1:0]          out_entry_key,
  output logic signed [kmat_pkg::RATE_W-1:0]     out_entry_max
);
  import kmat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_INS    = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic                     tab_r, tab_nxt;
  logic [SCAN_W-1:0]        scan_r, scan_nxt;
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic [SCAN_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [KEY_BITS-1:0]      a_key_r, a_key_nxt;
  logic [KEY_BITS-1:0]      r_key_r, r_key_nxt;
  logic signed [RATE_W-1:0] rating_r, rating_nxt;
  status_t                  a_stat_r, a_stat_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  logic [A_CNT_W-1:0]       a_fill_r, a_fill_nxt;
  logic [R_CNT_W-1:0]       r_fill_r, r_fill_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]        out_a_stat_r, out_a_stat_nxt;
  logic [STAT_W-1:0]        out_r_stat_r, out_r_stat_nxt;
  logic                     out_ev_r, out_ev_nxt;
  logic [IN_KEY_W-1:0]      out_key_r, out_key_nxt;
  logic signed [RATE_W-1:0] out_max_r, out_max_nxt;

  // store and compare unit hookup
  logic                     wr_en, rd_en;
  logic [ADDR_W-1:0]        wr_addr, rd_addr;
  logic [KEY_BITS-1:0]      wr_key, rd_key;
  logic signed [RATE_W-1:0] wr_max, rd_max;
  logic [KEY_BITS-1:0]      cur_key;
  logic signed [RATE_W-1:0] max_in;
  cmp_res_t                 cmp;

  // per-table view of the current search
  logic [SCAN_W-1:0]        n_cur, slots_cur;
  logic                     accept, hit;
  logic [CMP_W-1:0]         rd_idx_w, rd_fill_w, rd_slots_w;
  status_t                  tab_stat;
  logic                     tab_done;

  assign accept    = start && !busy;
  assign cur_key   = (tab_r == TAB_REGION) ? r_key_r : a_key_r;
  assign n_cur     = (tab_r == TAB_REGION) ? SCAN_W'(r_fill_r) : SCAN_W'(a_fill_r);
  assign slots_cur = (tab_r == TAB_REGION) ? SCAN_W'(REGION_SLOTS) : SCAN_W'(AGENT_SLOTS);
  assign hit       = (state_r == S_SEARCH) && cmp_vld_r && cmp.key_eq;
  assign max_in    = (state_r == S_INS) ? INIT_MAX : rd_max;

  // read request bounds check against table size and fill
  assign rd_idx_w   = CMP_W'(in_read_index);
  assign rd_fill_w  = (in_read_table == TAB_REGION) ? CMP_W'(r_fill_r) : CMP_W'(a_fill_r);
  assign rd_slots_w = (in_read_table == TAB_REGION) ? CMP_W'(REGION_SLOTS)
                                                    : CMP_W'(AGENT_SLOTS);

  kmat_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_key  (wr_key),
    .wr_max  (wr_max),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_max  (rd_max)
  );

  kmat_cmp u_cmp (
    .key_a  (cur_key),
    .key_b  (rd_key),
    .rating (rating_r),
    .max_in (max_in),
    .res    (cmp)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    tab_nxt        = tab_r;
    scan_nxt       = scan_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    a_key_nxt      = a_key_r;
    r_key_nxt      = r_key_r;
    rating_nxt     = rating_r;
    a_stat_nxt     = a_stat_r;
    rd_ok_nxt      = rd_ok_r;
    a_fill_nxt     = a_fill_r;
    r_fill_nxt     = r_fill_r;
    out_valid_nxt  = 1'b0;
    out_a_stat_nxt = out_a_stat_r;
    out_r_stat_nxt = out_r_stat_r;
    out_ev_nxt     = out_ev_r;
    out_key_nxt    = out_key_r;
    out_max_nxt    = out_max_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_key         = cur_key;
    wr_max         = cmp.new_max;
    rd_en          = 1'b0;
    rd_addr        = '0;
    tab_stat       = ST_MATCH;
    tab_done       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_key_nxt  = in_agent_key[KEY_BITS-1:0];
          r_key_nxt  = in_region_key[KEY_BITS-1:0];
          rating_nxt = in_rating;
          tab_nxt    = in_read_table;
          if (in_req_type == REQ_RECORD) begin
            tab_nxt     = TAB_AGENT;
            scan_nxt    = '0;
            cmp_vld_nxt = 1'b0;
            state_nxt   = S_SEARCH;
          end else begin
            // issue the slot read right away
            rd_ok_nxt = (rd_idx_w < rd_slots_w) && (rd_idx_w < rd_fill_w);
            rd_en     = 1'b1;
            rd_addr   = (in_read_table == TAB_REGION)
                        ? ADDR_W'(AGENT_SLOTS) + ADDR_W'(in_read_index)
                        : ADDR_W'(in_read_index);
            state_nxt = S_RESP;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          // matched: raise the stored maximum in place
          wr_en    = cmp.raise;
          wr_addr  = (tab_r == TAB_REGION) ? ADDR_W'(AGENT_SLOTS) + ADDR_W'(cmp_idx_r)
                                           : ADDR_W'(cmp_idx_r);
          wr_max   = rating_r;
          tab_stat = ST_MATCH;
          tab_done = 1'b1;
        end else if (scan_r >= n_cur) begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_INS;
        end else begin
          // one stored entry per cycle, compared the cycle after
          rd_en       = 1'b1;
          rd_addr     = (tab_r == TAB_REGION) ? ADDR_W'(AGENT_SLOTS) + ADDR_W'(scan_r)
                                              : ADDR_W'(scan_r);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = scan_r;
          scan_nxt    = scan_r + 1'b1;
        end
      end

      S_INS: begin
        tab_done = 1'b1;
        if (n_cur == slots_cur) begin
          tab_stat = ST_FULL;
        end else begin
          tab_stat = ST_INSERT;
          wr_en    = 1'b1;
          wr_addr  = (tab_r == TAB_REGION) ? ADDR_W'(AGENT_SLOTS) + ADDR_W'(n_cur)
                                           : ADDR_W'(n_cur);
          wr_max   = cmp.new_max;
          if (tab_r == TAB_REGION) begin
            r_fill_nxt = r_fill_r + 1'b1;
          end else begin
            a_fill_nxt = a_fill_r + 1'b1;
          end
        end
      end

      S_RESP: begin
        out_valid_nxt  = 1'b1;
        out_a_stat_nxt = ST_MATCH;
        out_r_stat_nxt = ST_MATCH;
        out_ev_nxt     = rd_ok_r;
        out_key_nxt    = rd_ok_r ? IN_KEY_W'(rd_key) : '0;
        out_max_nxt    = rd_ok_r ? rd_max : '0;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of one table: move on to region table or deliver the record result
    if (tab_done) begin
      if (tab_r == TAB_AGENT) begin
        a_stat_nxt  = tab_stat;
        tab_nxt     = TAB_REGION;
        scan_nxt    = '0;
        cmp_vld_nxt = 1'b0;
        state_nxt   = S_SEARCH;
      end else begin
        out_valid_nxt  = 1'b1;
        out_a_stat_nxt = a_stat_r;
        out_r_stat_nxt = tab_stat;
        out_ev_nxt     = 1'b0;
        out_key_nxt    = '0;
        out_max_nxt    = '0;
        state_nxt      = S_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      a_fill_r    <= '0;
      r_fill_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      a_fill_r    <= a_fill_nxt;
      r_fill_r    <= r_fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tab_r        <= tab_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    a_key_r      <= a_key_nxt;
    r_key_r      <= r_key_nxt;
    rating_r     <= rating_nxt;
    a_stat_r     <= a_stat_nxt;
    rd_ok_r      <= rd_ok_nxt;
    out_a_stat_r <= out_a_stat_nxt;
    out_r_stat_r <= out_r_stat_nxt;
    out_ev_r     <= out_ev_nxt;
    out_key_r    <= out_key_nxt;
    out_max_r    <= out_max_nxt;
  end

  // outputs
  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_agent_status  = out_a_stat_r;
  assign out_region_status = out_r_stat_r;
  assign out_entry_valid   = out_ev_r;
  assign out_entry_key     = out_key_r;
  assign out_entry_max     = out_max_r;

  // checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe while a request is still in work");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (a_fill_r <= A_CNT_W'(AGENT_SLOTS)) && (r_fill_r <= R_CNT_W'(REGION_SLOTS)))
    else $error("fill count beyond table size");

  a_ins_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> (state_r != S_INS))
    else $error("insert step held for more than one cycle");

endmodule
